// File: hdl/circle_intersection_points_unit_defines.svh
// assertion macros for the circle intersection checker
`ifndef CIRCLE_INTERSECTION_POINTS_UNIT_DEFINES_SVH
`define CIRCLE_INTERSECTION_POINTS_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define CIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define CIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cip_pkg.sv
package cip_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WW        = 128;

    localparam logic CMD_LINE   = 1'b0;
    localparam logic CMD_CIRCLE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic               command;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        radius;
        logic signed [31:0] line_a;
        logic signed [31:0] line_b;
        logic signed [31:0] line_c;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic [30:0]        other_radius;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [1:0]         point_count;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic     zero_line;
        t_in_item item;
    } t_job;

    function automatic logic [WW-1:0] sx128(input logic [31:0] v);
        return {{(WW-32){v[31]}}, v};
    endfunction

    function automatic logic fits32(input logic [WW-1:0] v);
        return (v[WW-1:31] == '0) || (v[WW-1:31] == '1);
    endfunction

    function automatic logic [31:0] sat32(input logic [WW-1:0] v);
        if (fits32(v)) begin
            return v[31:0];
        end
        return v[WW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    // limb pairs of a 4x4 limb product that land below 2^128
    function automatic logic [1:0] mul_i(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd2, 4'd4, 4'd7: r = 2'd1;
            4'd5, 4'd8:       r = 2'd2;
            4'd9:             r = 2'd3;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mul_j(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd1, 4'd4, 4'd8: r = 2'd1;
            4'd3, 4'd7:       r = 2'd2;
            4'd6:             r = 2'd3;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/cip_front.sv
module cip_front import cip_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output t_job     o_head,
    output logic     o_valid,
    input  logic     i_pop
);

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;
    t_job       job;

    // flag a line with both coefficients zero up front
    always_comb begin
        job.item      = i_item;
        job.zero_line = (i_item.command == CMD_LINE) &&
                        (i_item.line_a == '0) && (i_item.line_b == '0);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= job;
        end
    end

endmodule

// File: hdl/cip_mul.sv
module cip_mul import cip_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_a,
    input  logic [WW-1:0] i_b,
    output logic          o_done,
    output logic [WW-1:0] o_res
);

    // product mod 2^128 from ten 32x32 partial products, one per cycle
    logic          r_busy, r_ppv;
    logic [3:0]    r_k;
    logic [WW-1:0] r_a, r_b, r_acc;
    logic [63:0]   r_pp;
    logic [1:0]    r_sh;
    logic [31:0]   a_limb, b_limb;

    assign a_limb = r_a[{mul_i(r_k), 5'b0} +: 32];
    assign b_limb = r_b[{mul_j(r_k), 5'b0} +: 32];
    assign o_done = r_busy && (r_k == 4'd11);
    assign o_res  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_ppv  <= 1'b0;
                r_k    <= 4'd0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end
        end else begin
            if (r_k < 4'd10) begin
                r_pp  <= a_limb * b_limb;
                r_sh  <= mul_i(r_k) + mul_j(r_k);
                r_ppv <= 1'b1;
            end else begin
                r_ppv <= 1'b0;
            end
            if (r_ppv) begin
                r_acc <= r_acc + ({{(WW-64){1'b0}}, r_pp} << {r_sh, 5'b0});
            end
            if (r_k == 4'd11) begin
                r_busy <= 1'b0;
            end
            r_k <= r_k + 4'd1;
        end
    end

endmodule

// File: hdl/cip_div.sv
module cip_div import cip_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_a,
    input  logic [WW-1:0] i_b,
    output logic          o_done,
    output logic [WW-1:0] o_res
);

    // signed dividend, positive divisor, quotient truncated toward zero
    logic          r_busy, r_neg;
    logic [7:0]    r_cnt;
    logic [WW-1:0] r_n, r_d, r_q, r_rem;
    logic [WW-1:0] rem_sh;
    logic          ge;

    assign rem_sh = {r_rem[WW-2:0], r_n[WW-1]};
    assign ge     = (rem_sh >= r_d);
    assign o_done = r_busy && (r_cnt == 8'd129);
    assign o_res  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_a[WW-1];
                r_n    <= i_a[WW-1] ? -i_a : i_a;
                r_d    <= i_b;
                r_q    <= '0;
                r_rem  <= '0;
                r_cnt  <= 8'd0;
            end
        end else begin
            if (r_cnt < 8'd128) begin
                r_n   <= {r_n[WW-2:0], 1'b0};
                r_rem <= ge ? rem_sh - r_d : rem_sh;
                r_q   <= {r_q[WW-2:0], ge};
            end else if (r_cnt == 8'd128) begin
                r_q <= r_neg ? -r_q : r_q;
            end else begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 8'd1;
        end
    end

endmodule

// File: hdl/cip_sqrt.sv
module cip_sqrt import cip_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_a,
    output logic          o_done,
    output logic [WW-1:0] o_res
);

    // floor square root, one result bit per cycle
    logic          r_busy;
    logic [6:0]    r_cnt;
    logic [WW-1:0] r_n;
    logic [67:0]   r_rem;
    logic [63:0]   r_root;
    logic [67:0]   rem_sh, trial;
    logic          ge;

    assign rem_sh = {r_rem[65:0], r_n[WW-1:WW-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign o_done = r_busy && (r_cnt == 7'd64);
    assign o_res  = {{(WW-64){1'b0}}, r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= i_a;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 7'd0;
            end
        end else begin
            if (r_cnt < 7'd64) begin
                r_n    <= {r_n[WW-3:0], 2'b00};
                r_rem  <= ge ? rem_sh - trial : rem_sh;
                r_root <= {r_root[62:0], ge};
            end else begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 7'd1;
        end
    end

endmodule

// File: hdl/cip_back.sv
module cip_back import cip_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    input  logic [15:0] i_tol,
    output t_out_item   o_item,
    output logic        o_empty,
    input  logic        i_pop
);

    localparam logic [1:0] U_NONE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_SQRT = 2'd3;

    localparam logic [5:0] S_IDLE = 6'd0,  S_NONE = 6'd1,  S_OUT  = 6'd2,
                           L_AX   = 6'd3,  L_BY   = 6'd4,  L_AA   = 6'd5,
                           L_BB   = 6'd6,  L_NN   = 6'd7,  L_RR   = 6'd8,
                           L_RQ   = 6'd9,  L_P1   = 6'd10, L_P2   = 6'd11,
                           L_M1   = 6'd12, L_M2   = 6'd13, T_SQ   = 6'd14,
                           T_MA   = 6'd15, T_DA   = 6'd16, T_MB   = 6'd17,
                           T_DB   = 6'd18, L2_SQ  = 6'd19, L2_NA  = 6'd20,
                           L2_DNA = 6'd21, L2_NB  = 6'd22, L2_DNB = 6'd23,
                           L2_BS  = 6'd24, L2_DBS = 6'd25, L2_AS  = 6'd26,
                           L2_DAS = 6'd27, L2_P1  = 6'd28, C_DX2  = 6'd29,
                           C_DY2  = 6'd30, C_B1   = 6'd31, C_B2   = 6'd32,
                           C_W1   = 6'd33, C_W2   = 6'd34, C_OT1  = 6'd35,
                           C_OT2  = 6'd36, C_RR   = 6'd37, C_SS   = 6'd38,
                           C_LL   = 6'd39, C_U1   = 6'd40, C_U2   = 6'd41,
                           C_V1   = 6'd42, C_V2   = 6'd43, C_SQ   = 6'd44,
                           C_AX   = 6'd45, C_AY   = 6'd46, C_HX   = 6'd47,
                           C_HY   = 6'd48, C_D0X  = 6'd49, C_D0Y  = 6'd50,
                           C_D1X  = 6'd51, C_D1Y  = 6'd52;

    logic [5:0]    r_state, n_state, r_ret, n_ret;
    logic          r_wait, n_wait;
    logic [WW-1:0] r_cx, n_cx, r_cy, n_cy, r_r, n_r, r_rs, n_rs;
    logic [WW-1:0] r_a, n_a, r_b, n_b, r_t, n_t, r_n, n_n, r_q, n_q;
    logic [WW-1:0] r_n2, n_n2, r_r2q, n_r2q, r_s, n_s, r_el, n_el, r_l2, n_l2;
    logic [WW-1:0] r_ox, n_ox, r_oy, n_oy, r_mx, n_mx, r_my, n_my;
    logic [WW-1:0] r_px, n_px, r_py, n_py;
    logic [1:0]    r_cnt, n_cnt, r_stat, n_stat;
    logic          r_last, n_last, r_flip, n_flip;

    logic [1:0]    u_sel;
    logic [WW-1:0] opa, opb, u_res, mul_res, div_res, sqrt_res;
    logic          mul_done, div_done, sqrt_done, u_done, capt;
    logic [WW-1:0] tol, rp, rm, sum, diff, t_sp, t_sm, t_dm, t_dp;
    logic          r_lt_tol;

    // result queue
    t_out_item     r_ob [2];
    logic          r_owp, r_orp;
    logic [1:0]    r_ocnt;
    logic          ofull, opush, opop;
    t_out_item     oitem;

    assign tol      = {{(WW-16){1'b0}}, i_tol};
    assign rp       = r_r + tol;
    assign rm       = r_r - tol;
    assign r_lt_tol = (r_r < tol);
    assign sum      = r_r + r_rs;
    assign diff     = (r_r > r_rs) ? r_r - r_rs : r_rs - r_r;
    assign t_sp     = sum + tol;
    assign t_sm     = sum - tol;
    assign t_dm     = diff - tol;
    assign t_dp     = diff + tol;

    assign u_done = mul_done | div_done | sqrt_done;
    assign capt   = r_wait && u_done;

    always_comb begin
        unique case (u_sel)
            U_DIV:   u_res = div_res;
            U_SQRT:  u_res = sqrt_res;
            default: u_res = mul_res;
        endcase
    end

    cip_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((u_sel == U_MUL) && !r_wait),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    cip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((u_sel == U_DIV) && !r_wait),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    cip_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((u_sel == U_SQRT) && !r_wait),
        .i_a     (opa),
        .o_done  (sqrt_done),
        .o_res   (sqrt_res)
    );

    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_cx = r_cx; n_cy = r_cy; n_r = r_r; n_rs = r_rs;
        n_a = r_a; n_b = r_b; n_t = r_t; n_n = r_n; n_q = r_q;
        n_n2 = r_n2; n_r2q = r_r2q; n_s = r_s; n_el = r_el; n_l2 = r_l2;
        n_ox = r_ox; n_oy = r_oy; n_mx = r_mx; n_my = r_my;
        n_px = r_px; n_py = r_py;
        n_cnt = r_cnt; n_stat = r_stat; n_last = r_last; n_flip = r_flip;
        u_sel = U_NONE; opa = '0; opb = '0;
        o_job_pop = 1'b0; opush = 1'b0; oitem = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_cx = sx128(i_job.item.center_x);
                    n_cy = sx128(i_job.item.center_y);
                    n_r  = {{(WW-31){1'b0}}, i_job.item.radius};
                    n_rs = {{(WW-31){1'b0}}, i_job.item.other_radius};
                    if (i_job.item.command == CMD_LINE) begin
                        n_a = sx128(i_job.item.line_a);
                        n_b = sx128(i_job.item.line_b);
                        n_t = sx128(i_job.item.line_c) << FRAC_BITS;
                        if (i_job.zero_line) begin
                            n_stat  = ST_DEGEN;
                            n_state = S_NONE;
                        end else begin
                            n_state = L_AX;
                        end
                    end else begin
                        n_a = sx128(i_job.item.other_x) - sx128(i_job.item.center_x);
                        n_b = sx128(i_job.item.other_y) - sx128(i_job.item.center_y);
                        n_state = C_DX2;
                    end
                end
            end
            S_NONE: begin
                if (!ofull) begin
                    opush        = 1'b1;
                    oitem.status = r_stat;
                    oitem.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_OUT: begin
                if (!ofull) begin
                    opush             = 1'b1;
                    oitem.point_x     = sat32(r_px);
                    oitem.point_y     = sat32(r_py);
                    oitem.point_count = r_cnt;
                    oitem.status      = (fits32(r_px) && fits32(r_py)) ? ST_OK : ST_SAT;
                    oitem.last        = r_last;
                    n_state           = r_ret;
                end
            end
            // circle with line
            L_AX: begin
                u_sel = U_MUL; opa = r_a; opb = r_cx;
                if (capt) begin n_n = u_res; n_state = L_BY; end
            end
            L_BY: begin
                u_sel = U_MUL; opa = r_b; opb = r_cy;
                if (capt) begin n_n = r_n + u_res + r_t; n_state = L_AA; end
            end
            L_AA: begin
                u_sel = U_MUL; opa = r_a; opb = r_a;
                if (capt) begin n_q = u_res; n_state = L_BB; end
            end
            L_BB: begin
                u_sel = U_MUL; opa = r_b; opb = r_b;
                if (capt) begin n_q = r_q + u_res; n_state = L_NN; end
            end
            L_NN: begin
                u_sel = U_MUL; opa = r_n; opb = r_n;
                if (capt) begin n_n2 = u_res; n_state = L_RR; end
            end
            L_RR: begin
                u_sel = U_MUL; opa = r_r; opb = r_r;
                if (capt) begin n_t = u_res; n_state = L_RQ; end
            end
            L_RQ: begin
                u_sel = U_MUL; opa = r_t; opb = r_q;
                if (capt) begin n_r2q = u_res; n_state = L_P1; end
            end
            L_P1: begin
                u_sel = U_MUL; opa = rp; opb = rp;
                if (capt) begin n_t = u_res; n_state = L_P2; end
            end
            L_P2: begin
                u_sel = U_MUL; opa = r_t; opb = r_q;
                if (capt) begin
                    if (u_res < r_n2) begin
                        n_stat = ST_NONE; n_state = S_NONE;
                    end else if (r_lt_tol) begin
                        n_t = r_r2q; n_flip = !r_n[WW-1] && (r_n != '0);
                        n_state = T_SQ;
                    end else begin
                        n_state = L_M1;
                    end
                end
            end
            L_M1: begin
                u_sel = U_MUL; opa = rm; opb = rm;
                if (capt) begin n_t = u_res; n_state = L_M2; end
            end
            L_M2: begin
                u_sel = U_MUL; opa = r_t; opb = r_q;
                if (capt) begin
                    if (u_res < r_n2) begin
                        n_t = r_r2q; n_flip = !r_n[WW-1] && (r_n != '0);
                        n_state = T_SQ;
                    end else begin
                        n_t = r_r2q - r_n2; n_state = L2_SQ;
                    end
                end
            end
            // single point along the direction in a, b
            T_SQ: begin
                u_sel = U_SQRT; opa = r_t;
                if (capt) begin n_s = u_res; n_state = T_MA; end
            end
            T_MA: begin
                u_sel = U_MUL; opa = r_a; opb = r_s;
                if (capt) begin n_t = u_res; n_state = T_DA; end
            end
            T_DA: begin
                u_sel = U_DIV; opa = r_t; opb = r_q;
                if (capt) begin n_ox = u_res; n_state = T_MB; end
            end
            T_MB: begin
                u_sel = U_MUL; opa = r_b; opb = r_s;
                if (capt) begin n_t = u_res; n_state = T_DB; end
            end
            T_DB: begin
                u_sel = U_DIV; opa = r_t; opb = r_q;
                if (capt) begin
                    n_px   = r_flip ? r_cx - r_ox : r_cx + r_ox;
                    n_py   = r_flip ? r_cy - u_res : r_cy + u_res;
                    n_cnt  = 2'd1; n_last = 1'b1;
                    n_ret  = S_IDLE; n_state = S_OUT;
                end
            end
            // two points on a line
            L2_SQ: begin
                u_sel = U_SQRT; opa = r_t;
                if (capt) begin n_s = u_res; n_state = L2_NA; end
            end
            L2_NA: begin
                u_sel = U_MUL; opa = r_n; opb = r_a;
                if (capt) begin n_t = u_res; n_state = L2_DNA; end
            end
            L2_DNA: begin
                u_sel = U_DIV; opa = r_t; opb = r_q;
                if (capt) begin n_mx = r_cx - u_res; n_state = L2_NB; end
            end
            L2_NB: begin
                u_sel = U_MUL; opa = r_n; opb = r_b;
                if (capt) begin n_t = u_res; n_state = L2_DNB; end
            end
            L2_DNB: begin
                u_sel = U_DIV; opa = r_t; opb = r_q;
                if (capt) begin n_my = r_cy - u_res; n_state = L2_BS; end
            end
            L2_BS: begin
                u_sel = U_MUL; opa = r_b; opb = r_s;
                if (capt) begin n_t = u_res; n_state = L2_DBS; end
            end
            L2_DBS: begin
                u_sel = U_DIV; opa = r_t; opb = r_q;
                if (capt) begin n_ox = u_res; n_state = L2_AS; end
            end
            L2_AS: begin
                u_sel = U_MUL; opa = r_a; opb = r_s;
                if (capt) begin n_t = u_res; n_state = L2_DAS; end
            end
            L2_DAS: begin
                u_sel = U_DIV; opa = r_t; opb = r_q;
                if (capt) begin
                    n_oy  = u_res;
                    n_px  = r_mx - r_ox; n_py = r_my + u_res;
                    n_cnt = 2'd2; n_last = 1'b0;
                    n_ret = L2_P1; n_state = S_OUT;
                end
            end
            L2_P1: begin
                n_px  = r_mx + r_ox; n_py = r_my - r_oy;
                n_cnt = 2'd2; n_last = 1'b1;
                n_ret = S_IDLE; n_state = S_OUT;
            end
            // circle with circle
            C_DX2: begin
                u_sel = U_MUL; opa = r_a; opb = r_a;
                if (capt) begin n_q = u_res; n_state = C_DY2; end
            end
            C_DY2: begin
                u_sel = U_MUL; opa = r_b; opb = r_b;
                if (capt) begin n_q = r_q + u_res; n_state = C_B1; end
            end
            C_B1: begin
                u_sel = U_MUL; opa = t_sp; opb = t_sp;
                if (capt) begin
                    if (u_res < r_q) begin
                        n_stat = ST_NONE; n_state = S_NONE;
                    end else begin
                        n_state = C_B2;
                    end
                end
            end
            C_B2: begin
                u_sel = U_MUL; opa = t_sm; opb = t_sm;
                if (capt) begin
                    if (t_sm[WW-1] || (u_res < r_q)) begin
                        if (r_q == '0) begin
                            n_stat = ST_DEGEN; n_state = S_NONE;
                        end else begin
                            n_flip = 1'b0; n_state = C_OT1;
                        end
                    end else begin
                        n_state = C_W1;
                    end
                end
            end
            C_W1: begin
                u_sel = U_MUL; opa = t_dm; opb = t_dm;
                if (capt) begin
                    if (!t_dm[WW-1] && (t_dm != '0) && (r_q < u_res)) begin
                        n_stat = ST_NONE; n_state = S_NONE;
                    end else begin
                        n_state = C_W2;
                    end
                end
            end
            C_W2: begin
                u_sel = U_MUL; opa = t_dp; opb = t_dp;
                if (capt) begin
                    if (r_q == '0) begin
                        n_stat = ST_DEGEN; n_state = S_NONE;
                    end else if (!t_dp[WW-1] && (t_dp != '0) && (r_q < u_res)) begin
                        n_flip = (r_r < r_rs); n_state = C_OT1;
                    end else begin
                        n_state = C_RR;
                    end
                end
            end
            C_OT1: begin
                u_sel = U_MUL; opa = r_r; opb = r_r;
                if (capt) begin n_t = u_res; n_state = C_OT2; end
            end
            C_OT2: begin
                u_sel = U_MUL; opa = r_t; opb = r_q;
                if (capt) begin n_t = u_res; n_state = T_SQ; end
            end
            C_RR: begin
                u_sel = U_MUL; opa = r_r; opb = r_r;
                if (capt) begin n_el = r_q + u_res; n_state = C_SS; end
            end
            C_SS: begin
                u_sel = U_MUL; opa = r_rs; opb = r_rs;
                if (capt) begin n_el = r_el - u_res; n_state = C_LL; end
            end
            C_LL: begin
                u_sel = U_MUL; opa = r_el; opb = r_el;
                if (capt) begin n_l2 = u_res; n_state = C_U1; end
            end
            C_U1: begin
                u_sel = U_MUL; opa = rm << 1; opb = rm << 1;
                if (capt) begin n_t = u_res; n_state = C_U2; end
            end
            C_U2: begin
                u_sel = U_MUL; opa = r_t; opb = r_q;
                if (capt) begin
                    if (r_lt_tol || (u_res < r_l2)) begin
                        n_flip = r_el[WW-1]; n_state = C_OT1;
                    end else begin
                        n_state = C_V1;
                    end
                end
            end
            C_V1: begin
                u_sel = U_MUL; opa = r_r << 1; opb = r_r << 1;
                if (capt) begin n_t = u_res; n_state = C_V2; end
            end
            C_V2: begin
                u_sel = U_MUL; opa = r_t; opb = r_q;
                if (capt) begin n_t = u_res - r_l2; n_state = C_SQ; end
            end
            C_SQ: begin
                u_sel = U_SQRT; opa = r_t;
                if (capt) begin n_s = u_res; n_q = r_q + r_q; n_state = C_AX; end
            end
            C_AX: begin
                u_sel = U_MUL; opa = r_a; opb = r_el;
                if (capt) begin n_mx = u_res; n_state = C_AY; end
            end
            C_AY: begin
                u_sel = U_MUL; opa = r_b; opb = r_el;
                if (capt) begin n_my = u_res; n_state = C_HX; end
            end
            C_HX: begin
                u_sel = U_MUL; opa = r_b; opb = r_s;
                if (capt) begin n_ox = u_res; n_state = C_HY; end
            end
            C_HY: begin
                u_sel = U_MUL; opa = r_a; opb = r_s;
                if (capt) begin n_oy = u_res; n_state = C_D0X; end
            end
            C_D0X: begin
                u_sel = U_DIV; opa = r_mx - r_ox; opb = r_q;
                if (capt) begin n_px = r_cx + u_res; n_state = C_D0Y; end
            end
            C_D0Y: begin
                u_sel = U_DIV; opa = r_my + r_oy; opb = r_q;
                if (capt) begin
                    n_py  = r_cy + u_res;
                    n_cnt = 2'd2; n_last = 1'b0;
                    n_ret = C_D1X; n_state = S_OUT;
                end
            end
            C_D1X: begin
                u_sel = U_DIV; opa = r_mx + r_ox; opb = r_q;
                if (capt) begin n_px = r_cx + u_res; n_state = C_D1Y; end
            end
            C_D1Y: begin
                u_sel = U_DIV; opa = r_my - r_oy; opb = r_q;
                if (capt) begin
                    n_py  = r_cy + u_res;
                    n_cnt = 2'd2; n_last = 1'b1;
                    n_ret = S_IDLE; n_state = S_OUT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a unit call stays open until its done pulse
        n_wait = r_wait ? !u_done : (u_sel != U_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_cx <= n_cx; r_cy <= n_cy; r_r <= n_r; r_rs <= n_rs;
        r_a <= n_a; r_b <= n_b; r_t <= n_t; r_n <= n_n; r_q <= n_q;
        r_n2 <= n_n2; r_r2q <= n_r2q; r_s <= n_s; r_el <= n_el; r_l2 <= n_l2;
        r_ox <= n_ox; r_oy <= n_oy; r_mx <= n_mx; r_my <= n_my;
        r_px <= n_px; r_py <= n_py;
        r_cnt <= n_cnt; r_stat <= n_stat; r_last <= n_last; r_flip <= n_flip;
    end

    assign ofull   = (r_ocnt == 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_item  = r_ob[r_orp];
    assign opop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (opush) begin
                r_owp <= !r_owp;
            end
            if (opop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, opush} - {1'b0, opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_ob[r_owp] <= oitem;
        end
    end

endmodule

// File: hdl/circle_intersection_points_unit.sv
// channel   direction  handshake                 payload
// input     in         push / full               i_in  (t_in_item)
// result    out        pop / empty               o_out (t_out_item)
// config    in         i_cfg_we, no wait         i_cfg_wdata (tolerance)
//
// items are taken into a two-deep front queue, one per cycle while it has room
// each item then passes through the back sequencer, from a zero line (no unit call) up to two circle points,
// driving the shared 128-bit units: multiply, divide and square root
// synchronous active-low reset clears both queues, the sequencer and tolerance (to 1)
// results wait in a two-deep output queue; with pop low it fills and stalls the back,
// then the front queue fills and raises full
module circle_intersection_points_unit import cip_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    // tangency tolerance, raw fixed-point units
    logic [15:0] r_tol;

    // front to back: head of the classified job queue
    t_job job_head;
    logic job_valid;
    logic job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd1;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // accepts items and flags degenerate lines
    cip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in),
        .o_full  (full),
        .o_head  (job_head),
        .o_valid (job_valid),
        .i_pop   (job_pop)
    );

    // sequences the exact wide arithmetic and queues the results
    cip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_tol       (r_tol),
        .o_item      (o_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// File: hdl/cip_checker.sv
`include "circle_intersection_points_unit_defines.svh"

module cip_checker import cip_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out
);

    // queue comes out of reset empty
    `CIP_ASSERT_NOW(a_empty_after_reset, $past(!i_rst_n), empty, "result queue not empty after reset")

    // no point: zero coordinates, no-intersection or degenerate status, item closed
    `CIP_ASSERT_NOW(a_none_form, !empty && (o_out.point_count == 2'd0), (o_out.point_x == 32'sd0) && (o_out.point_y == 32'sd0) && o_out.last && ((o_out.status == ST_NONE) || (o_out.status == ST_DEGEN)), "malformed no-point result")

    // a single point always closes its item
    `CIP_ASSERT_NOW(a_single_last, !empty && (o_out.point_count == 2'd1), o_out.last && ((o_out.status == ST_OK) || (o_out.status == ST_SAT)), "single point result not final")

    // a waiting result holds until taken
    `CIP_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_out), "waiting result changed")

endmodule

bind circle_intersection_points_unit cip_checker u_cip_checker (.*);
